/* sv/uoq_pkg.sv */
package uoq_pkg;

  localparam int DistW   = 16;
  localparam int GroupW  = 2;
  localparam int TimeW   = 32;
  localparam int RespW   = 2;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 3;
  localparam int RunW    = 2;

  localparam logic [RunW-1:0] RunDetect = RunW'(2);

  // Register reset values.
  localparam logic [CfgW-1:0] FrontLowRst   = CfgW'(100);
  localparam logic [CfgW-1:0] FrontHighRst  = CfgW'(1500);
  localparam logic [CfgW-1:0] UpperLowRst   = CfgW'(10);
  localparam logic [CfgW-1:0] UpperHighRst  = CfgW'(1000);
  localparam logic [CfgW-1:0] NoiseLowRst   = CfgW'(10);
  localparam logic [CfgW-1:0] NoiseHighRst  = CfgW'(1500);
  localparam logic [CfgW-1:0] ProtectionRst = CfgW'(3000);
  localparam logic [CfgW-1:0] StopHoldRst   = CfgW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRONT_LOW  = 3'd0,
    CFG_FRONT_HIGH = 3'd1,
    CFG_UPPER_LOW  = 3'd2,
    CFG_UPPER_HIGH = 3'd3,
    CFG_NOISE_LOW  = 3'd4,
    CFG_NOISE_HIGH = 3'd5,
    CFG_PROTECTION = 3'd6,
    CFG_STOP_HOLD  = 3'd7
  } cfg_idx_e;

  typedef enum logic [GroupW-1:0] {
    GRP_FRONT = 2'd0,
    GRP_UPPER = 2'd1,
    GRP_NOISE = 2'd2,
    GRP_NONE  = 2'd3
  } group_e;

  typedef enum logic [RespW-1:0] {
    RESP_NONE    = 2'd0,
    RESP_HIT     = 2'd1,
    RESP_HITTING = 2'd2,
    RESP_ESTOP   = 2'd3
  } resp_e;

  typedef struct packed {
    logic [CfgW-1:0] front_low;
    logic [CfgW-1:0] front_high;
    logic [CfgW-1:0] upper_low;
    logic [CfgW-1:0] upper_high;
    logic [CfgW-1:0] noise_low;
    logic [CfgW-1:0] noise_high;
    logic [CfgW-1:0] protection_ms;
    logic [CfgW-1:0] stop_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [GroupW-1:0] group;
    logic              scan_end;
    logic [TimeW-1:0]  now_ms;
  } item_t;

endpackage

/* sv/uoq_cfg_regs.sv */
module uoq_cfg_regs import uoq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_low     <= FrontLowRst;
      cfg_q.front_high    <= FrontHighRst;
      cfg_q.upper_low     <= UpperLowRst;
      cfg_q.upper_high    <= UpperHighRst;
      cfg_q.noise_low     <= NoiseLowRst;
      cfg_q.noise_high    <= NoiseHighRst;
      cfg_q.protection_ms <= ProtectionRst;
      cfg_q.stop_hold_ms  <= StopHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRONT_LOW:  cfg_q.front_low     <= cfg_wdata_i;
        CFG_FRONT_HIGH: cfg_q.front_high    <= cfg_wdata_i;
        CFG_UPPER_LOW:  cfg_q.upper_low     <= cfg_wdata_i;
        CFG_UPPER_HIGH: cfg_q.upper_high    <= cfg_wdata_i;
        CFG_NOISE_LOW:  cfg_q.noise_low     <= cfg_wdata_i;
        CFG_NOISE_HIGH: cfg_q.noise_high    <= cfg_wdata_i;
        CFG_PROTECTION: cfg_q.protection_ms <= cfg_wdata_i;
        CFG_STOP_HOLD:  cfg_q.stop_hold_ms  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/uoq_core.sv */
module uoq_core import uoq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output resp_e resp_o
);

  logic [RunW-1:0]  front_run_q, front_run_d;
  logic             seen_obs_q, seen_obs_d;
  logic             seen_noise_q, seen_noise_d;
  logic [TimeW-1:0] first_hit_q, first_hit_d;
  logic             hit_valid_q, hit_valid_d;
  logic [TimeW-1:0] stop_time_q, stop_time_d;
  resp_e            last_resp_q, last_resp_d;

  logic             front_in, upper_in, noise_in, detect;
  logic [TimeW-1:0] freeze_at, hold_until;
  resp_e            resp;

  assign front_in = (item_i.distance >= cfg_i.front_low) &&
                    (item_i.distance <= cfg_i.front_high);
  assign upper_in = (item_i.distance >= cfg_i.upper_low) &&
                    (item_i.distance <= cfg_i.upper_high);
  assign noise_in = (item_i.distance >= cfg_i.noise_low) &&
                    (item_i.distance <= cfg_i.noise_high);

  always_comb begin
    front_run_d  = front_run_q;
    seen_obs_d   = seen_obs_q;
    seen_noise_d = seen_noise_q;
    case (group_e'(item_i.group))
      GRP_FRONT: begin
        if (front_run_q < RunDetect) begin
          front_run_d = front_in ? front_run_q + RunW'(1) : '0;
        end
      end
      GRP_UPPER: seen_obs_d   = seen_obs_q | upper_in;
      GRP_NOISE: seen_noise_d = seen_noise_q | noise_in;
      default: ;
    endcase

    detect      = (front_run_d >= RunDetect) || seen_obs_d || seen_noise_d;
    freeze_at   = first_hit_q + TimeW'(cfg_i.protection_ms);
    first_hit_d = first_hit_q;
    hit_valid_d = hit_valid_q;
    stop_time_d = stop_time_q;
    resp        = last_resp_q;
    if (detect) begin
      if (seen_noise_d) begin
        resp        = RESP_ESTOP;
        stop_time_d = item_i.now_ms;
      end else if (hit_valid_q && (freeze_at <= item_i.now_ms)) begin
        resp = last_resp_q;
      end else if (!hit_valid_q) begin
        resp        = RESP_HIT;
        first_hit_d = item_i.now_ms;
        hit_valid_d = 1'b1;
      end else begin
        resp = RESP_HITTING;
      end
    end else begin
      resp        = RESP_NONE;
      hit_valid_d = 1'b0;
    end

    hold_until = stop_time_d + TimeW'(cfg_i.stop_hold_ms);
    if (hold_until > item_i.now_ms) begin
      resp = RESP_ESTOP;
    end
    last_resp_d = resp;
  end

  assign resp_o = resp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_run_q  <= '0;
      seen_obs_q   <= 1'b0;
      seen_noise_q <= 1'b0;
      first_hit_q  <= '0;
      hit_valid_q  <= 1'b0;
      stop_time_q  <= '0;
      last_resp_q  <= RESP_NONE;
    end else if (step_i) begin
      if (item_i.scan_end) begin
        front_run_q  <= '0;
        seen_obs_q   <= 1'b0;
        seen_noise_q <= 1'b0;
        first_hit_q  <= first_hit_d;
        hit_valid_q  <= hit_valid_d;
        stop_time_q  <= stop_time_d;
        last_resp_q  <= last_resp_d;
      end else begin
        front_run_q  <= front_run_d;
        seen_obs_q   <= seen_obs_d;
        seen_noise_q <= seen_noise_d;
      end
    end
  end

endmodule

/* sv/ultrasonic_obstacle_qualifier.sv */
// Ultrasonic obstacle qualifier. Readings of one scan arrive one per transfer on the
// slave stream, tagged in tuser with their sensor group and with tlast on the last
// reading of the scan. Each scan yields exactly one response transfer on the master
// stream (none, hit, hitting or emergency stop); readings without tlast yield none.
// The block takes one reading per clock cycle unless stalled: a reading waits in the input
// register while the combinational qualifier logic updates the scan state, and for a
// tlast reading the response is captured into the output register when the reading
// leaves the input register. Only the output register can stall the flow, and only for
// readings that carry tlast. Write configuration registers through the cfg port only
// while no transfer is in flight.
module ultrasonic_obstacle_qualifier import uoq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,  // distance [15:0], now_ms [47:16]
  input  logic [1:0]         s_axis_tuser,  // group [1:0]
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // response [1:0], zero fill [7:2]
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  logic  out_valid_q;
  resp_e out_resp_q;
  resp_e resp;
  logic  advance;

  uoq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // A reading leaves the input register unless it ends a scan and the
  // output register still holds a response that has not been taken.
  assign advance       = in_valid_q && (!item_q.scan_end || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.distance <= s_axis_tdata[DistW-1:0];
      item_q.now_ms   <= s_axis_tdata[DistW +: TimeW];
      item_q.group    <= s_axis_tuser;
      item_q.scan_end <= s_axis_tlast;
    end
  end

  uoq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .resp_o (resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && item_q.scan_end) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_q.scan_end) begin
      out_resp_q <= resp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_resp_q};

endmodule

/* dv/uoq_scan_checker.sv */
module uoq_scan_checker import uoq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,  // distance [15:0], now_ms [47:16]
  input  logic [1:0]         s_axis_tuser,  // group [1:0]
  input  logic               s_axis_tlast,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [7:0]         m_axis_tdata,  // response [1:0], zero fill [7:2]
  output int                 fail_count,
  output int                 outstanding
);

  cfg_t             regs;
  logic [RunW-1:0]  front_run;
  logic             seen_obstacle;
  logic             seen_noise;
  logic [TimeW-1:0] first_hit_time;
  logic             hit_valid;
  logic [TimeW-1:0] stop_time;
  resp_e            last_response;
  resp_e            response_q[$];
  int               mismatches = 0;
  int               pending_n = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending_n;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] response check: %s", $time, what);
  endtask

  function automatic logic in_band(input logic [DistW-1:0] d, input logic [CfgW-1:0] lo,
                                   input logic [CfgW-1:0] hi);
    return (d >= lo) && (d <= hi);
  endfunction

  // Folds one reading into the scan state; a reading with scan_end queues the
  // response that the scan should produce.
  task automatic qualify_reading(input logic [DistW-1:0] dst, input group_e grp,
                                 input logic scan_end, input logic [TimeW-1:0] now);
    logic             detect;
    logic [TimeW-1:0] protect_end;
    logic [TimeW-1:0] hold_end;
    resp_e            resp;
    case (grp)
      GRP_FRONT: begin
        if (front_run < RunDetect)
          front_run = in_band(dst, regs.front_low, regs.front_high) ? front_run + 1'b1 : '0;
      end
      GRP_UPPER: begin
        if (in_band(dst, regs.upper_low, regs.upper_high)) seen_obstacle = 1'b1;
      end
      GRP_NOISE: begin
        if (in_band(dst, regs.noise_low, regs.noise_high)) seen_noise = 1'b1;
      end
      default: ;
    endcase
    if (scan_end) begin
      detect = (front_run >= RunDetect) || seen_obstacle || seen_noise;
      resp = last_response;
      if (detect) begin
        protect_end = first_hit_time + {16'h0, regs.protection_ms};
        if (seen_noise) begin
          resp = RESP_ESTOP;
          stop_time = now;
        end else if (!hit_valid) begin
          resp = RESP_HIT;
          first_hit_time = now;
          hit_valid = 1'b1;
        end else if (protect_end > now) begin
          resp = RESP_HITTING;
        end
        // Otherwise the detection is old enough that the response stays frozen.
      end else begin
        resp = RESP_NONE;
        hit_valid = 1'b0;
      end
      hold_end = stop_time + {16'h0, regs.stop_hold_ms};
      if (hold_end > now) resp = RESP_ESTOP;
      last_response = resp;
      front_run = '0;
      seen_obstacle = 1'b0;
      seen_noise = 1'b0;
      response_q.push_back(resp);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    resp_e got;
    resp_e want;
    if (!rst_ni) begin
      regs.front_low     = FrontLowRst;
      regs.front_high    = FrontHighRst;
      regs.upper_low     = UpperLowRst;
      regs.upper_high    = UpperHighRst;
      regs.noise_low     = NoiseLowRst;
      regs.noise_high    = NoiseHighRst;
      regs.protection_ms = ProtectionRst;
      regs.stop_hold_ms  = StopHoldRst;
      front_run      = '0;
      seen_obstacle  = 1'b0;
      seen_noise     = 1'b0;
      first_hit_time = '0;
      hit_valid      = 1'b0;
      stop_time      = '0;
      last_response  = RESP_NONE;
      response_q.delete();
      pending_n <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FRONT_LOW:  regs.front_low     = cfg_wdata_i;
          CFG_FRONT_HIGH: regs.front_high    = cfg_wdata_i;
          CFG_UPPER_LOW:  regs.upper_low     = cfg_wdata_i;
          CFG_UPPER_HIGH: regs.upper_high    = cfg_wdata_i;
          CFG_NOISE_LOW:  regs.noise_low     = cfg_wdata_i;
          CFG_NOISE_HIGH: regs.noise_high    = cfg_wdata_i;
          CFG_PROTECTION: regs.protection_ms = cfg_wdata_i;
          CFG_STOP_HOLD:  regs.stop_hold_ms  = cfg_wdata_i;
          default: ;
        endcase
      end
      // Responses are matched before new readings are folded in, so a response
      // transfer can never be paired with a scan that ends on the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got = resp_e'(m_axis_tdata[RespW-1:0]);
        if (response_q.size() == 0) begin
          report_mismatch($sformatf("response %s with no scan waiting", got.name()));
        end else begin
          want = response_q.pop_front();
          if (m_axis_tdata[RespW-1:0] !== want)
            report_mismatch($sformatf("response %0h, expected %s",
                                      m_axis_tdata[RespW-1:0], want.name()));
          if (m_axis_tdata[7:RespW] !== '0)
            report_mismatch($sformatf("fill bits %0h are not zero", m_axis_tdata[7:RespW]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        qualify_reading(s_axis_tdata[DistW-1:0], group_e'(s_axis_tuser), s_axis_tlast,
                        s_axis_tdata[DistW +: TimeW]);
      pending_n <= response_q.size();
    end
  end

endmodule

/* dv/ultrasonic_obstacle_qualifier_test.sv */
// Stimulus and verdict for the obstacle qualifier. The checker beside the block
// watches both streams and the register port and predicts every response.
module ultrasonic_obstacle_qualifier_test;
  import uoq_pkg::*;

  // Consecutive cycles without any transfer or register write before the run
  // is declared hung.
  localparam int StallLimit   = 300;
  localparam int ItemsPerPass = 130;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata = '0;   // distance [15:0], now_ms [47:16]
  logic [1:0]         s_axis_tuser = '0;   // group [1:0]
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;        // response [1:0], zero fill [7:2]

  int fail_count;
  int outstanding;

  // Register values currently loaded; used to aim distances at the edges and to size time steps.
  cfg_t             settings;
  logic [TimeW-1:0] clock_ms = '0;
  int               burst_left = 0;
  int               items_sent = 0;
  int               stall_left = 0;
  int               idle_cycles = 0;
  bit               sender_gaps = 1'b1;
  bit               receiver_stalls = 1'b1;

  ultrasonic_obstacle_qualifier dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  uoq_scan_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count,
    .outstanding
  );

  always #10 clk_i = ~clk_i;

  // The response sink stalls in short random stretches of its own. With stalls
  // switched off it is always ready, which exercises back-to-back responses.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (receiver_stalls && $urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 6);
    end
  end

  // Hang detection: any transfer on either stream or any register write counts
  // as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write per cycle. The write enable is left high so that a run
  // of writes never drops and raises it within one time step.
  task automatic put_register(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    settings = s;
    put_register(CFG_FRONT_LOW,  s.front_low);
    put_register(CFG_FRONT_HIGH, s.front_high);
    put_register(CFG_UPPER_LOW,  s.upper_low);
    put_register(CFG_UPPER_HIGH, s.upper_high);
    put_register(CFG_NOISE_LOW,  s.noise_low);
    put_register(CFG_NOISE_HIGH, s.noise_high);
    put_register(CFG_PROTECTION, s.protection_ms);
    put_register(CFG_STOP_HOLD,  s.stop_hold_ms);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one reading and returns at the edge where it is transferred. The
  // sender works in bursts; a gap before a burst drops tvalid.
  task automatic send_reading(input logic [DistW-1:0] dst, input group_e grp,
                              input logic last, input logic [TimeW-1:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {now, dst};
    s_axis_tuser <= grp;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Lets every queued response come out, then lets the input and output registers
  // empty so that no reading is still in flight when registers change.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Distances cluster on the range bounds and just outside them, with the rest
  // spread inside the range and over the whole field.
  function automatic logic [DistW-1:0] pick_distance(input logic [CfgW-1:0] lo,
                                                     input logic [CfgW-1:0] hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return lo - 1'b1;
      3: return hi + 1'b1;
      4, 5, 6: return (lo <= hi) ? DistW'($urandom_range(lo, hi)) : DistW'($urandom());
      7: return '0;
      8: return '1;
      default: return DistW'($urandom());
    endcase
  endfunction

  // A scan of up to six readings. Mostly small time steps keep detections alive
  // long enough to reach the protection freeze; the occasional large jump or
  // exact register-sized step hits the wrap and the boundaries of both timers.
  task automatic random_scan();
    int               n;
    int               r;
    group_e           grp;
    logic [DistW-1:0] dst;
    r = $urandom_range(0, 99);
    if (r < 70)      clock_ms += $urandom_range(0, 400);
    else if (r < 88) clock_ms += $urandom_range(0, 4000);
    else if (r < 93) clock_ms += settings.protection_ms;
    else if (r < 97) clock_ms += settings.stop_hold_ms;
    else             clock_ms = $urandom();
    n = $urandom_range(0, 5);
    for (int k = 0; k <= n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50)      grp = GRP_FRONT;
      else if (r < 72) grp = GRP_UPPER;
      else if (r < 82) grp = GRP_NOISE;
      else             grp = GRP_NONE;
      case (grp)
        GRP_FRONT: dst = pick_distance(settings.front_low, settings.front_high);
        GRP_UPPER: dst = pick_distance(settings.upper_low, settings.upper_high);
        GRP_NOISE: dst = pick_distance(settings.noise_low, settings.noise_high);
        default:   dst = DistW'($urandom());
      endcase
      // Only the time on the closing reading matters; the others carry noise.
      send_reading(dst, grp, k == n,
                   (k == n || $urandom_range(0, 1) == 0) ? clock_ms : TimeW'($urandom()));
    end
  endtask

  task automatic random_pass(input cfg_t s);
    int first_item;
    drain();
    load_settings(s);
    sender_gaps = $urandom_range(0, 3) != 0;
    receiver_stalls = $urandom_range(0, 3) != 0;
    // Some passes start just below the 32-bit wrap of the millisecond clock.
    clock_ms = $urandom_range(0, 1) ? TimeW'($urandom()) : 32'hFFFF_F000 + $urandom_range(0, 4000);
    first_item = items_sent;
    while (items_sent - first_item < ItemsPerPass) random_scan();
  endtask

  initial begin
    cfg_t s;
    settings = '{FrontLowRst, FrontHighRst, UpperLowRst, UpperHighRst,
                 NoiseLowRst, NoiseHighRst, ProtectionRst, StopHoldRst};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed scans on the reset register values, with no gaps or stalls.
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    // Just after reset the stop hold still covers small times: a front detection
    // at 5 ms comes out as an emergency stop.
    send_reading(16'd100, GRP_FRONT, 1'b0, 32'd5);
    send_reading(16'd1500, GRP_FRONT, 1'b1, 32'd5);
    // Front readings one below and one above the range: nothing.
    send_reading(16'd99, GRP_FRONT, 1'b0, 32'd2000);
    send_reading(16'd1501, GRP_FRONT, 1'b1, 32'd2000);
    // An out-of-range front reading breaks the run.
    send_reading(16'd100, GRP_FRONT, 1'b0, 32'd2100);
    send_reading(16'd99, GRP_FRONT, 1'b0, 32'd2100);
    send_reading(16'd1500, GRP_FRONT, 1'b1, 32'd2100);
    // Front detection holds after a later miss, and a group-three reading that
    // is otherwise ignored still closes the scan: first hit.
    send_reading(16'd100, GRP_FRONT, 1'b0, 32'd2200);
    send_reading(16'd1500, GRP_FRONT, 1'b0, 32'd2200);
    send_reading(16'd0, GRP_FRONT, 1'b0, 32'd2200);
    send_reading(16'd500, GRP_NONE, 1'b1, 32'd2200);
    // Upper bar at its low bound keeps the detection going: hitting.
    send_reading(16'd10, GRP_UPPER, 1'b1, 32'd2300);
    // Upper bar just outside both bounds: nothing.
    send_reading(16'd9, GRP_UPPER, 1'b0, 32'd2400);
    send_reading(16'd1001, GRP_UPPER, 1'b1, 32'd2400);
    // Noise at its high bound forces an emergency stop.
    send_reading(16'hFFFF, GRP_FRONT, 1'b0, 32'd2500);
    send_reading(16'd1500, GRP_NOISE, 1'b1, 32'd2500);
    // Hold over; a fresh upper detection is a first hit, then exactly the
    // protection time later the response freezes.
    send_reading(16'd1000, GRP_UPPER, 1'b1, 32'd5000);
    send_reading(16'd500, GRP_UPPER, 1'b1, 32'd8000);
    // Noise just outside its range, then a lone ignored reading ending a scan.
    send_reading(16'd9, GRP_NOISE, 1'b0, 32'd8100);
    send_reading(16'd1501, GRP_NOISE, 1'b0, 32'd8100);
    send_reading(16'd0, GRP_FRONT, 1'b1, 32'd8100);
    send_reading(16'hFFFF, GRP_NONE, 1'b1, 32'hFFFF_FFFF);

    // Moderate random ranges and timers.
    s.front_low = $urandom_range(0, 2000);
    s.front_high = $urandom_range(2000, 30000);
    s.upper_low = $urandom_range(0, 2000);
    s.upper_high = $urandom_range(2000, 30000);
    s.noise_low = $urandom_range(0, 2000);
    s.noise_high = $urandom_range(2000, 30000);
    s.protection_ms = $urandom_range(500, 5000);
    s.stop_hold_ms = $urandom_range(0, 800);
    random_pass(s);

    // Everything in range, no protection and no hold.
    s = '{16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'h0};
    random_pass(s);

    // Inverted ranges: nothing is ever in range; longest timers.
    s = '{16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF};
    random_pass(s);

    // Single-point ranges with one-millisecond timers.
    s.front_low = $urandom();
    s.front_high = s.front_low;
    s.upper_low = $urandom();
    s.upper_high = s.upper_low;
    s.noise_low = $urandom();
    s.noise_high = s.noise_low;
    s.protection_ms = 16'd1;
    s.stop_hold_ms = 16'd1;
    random_pass(s);

    // Fully random registers, inverted ranges included when they fall that way.
    s = cfg_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    random_pass(s);

    // Back to the power-on values with a short stop hold.
    s = '{FrontLowRst, FrontHighRst, UpperLowRst, UpperHighRst,
          NoiseLowRst, NoiseHighRst, ProtectionRst, 16'd200};
    random_pass(s);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/uoq_pkg.sv
sv/uoq_cfg_regs.sv
sv/uoq_core.sv
sv/ultrasonic_obstacle_qualifier.sv
dv/uoq_scan_checker.sv
dv/ultrasonic_obstacle_qualifier_test.sv
